### rtl/cubemap_to_spheremap_address_assert.svh
// Assertion macros for the cube map to sphere map address block.
// No dependencies; included by the files that carry assertions.
`ifndef CUBEMAP_TO_SPHEREMAP_ADDRESS_ASSERT_SVH
`define CUBEMAP_TO_SPHEREMAP_ADDRESS_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define C2S_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent a fixed number of cycles later
`define C2S_ASSERT_DELAY(label, clk, rst_n, ante, n, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
        else $error(msg);

`endif

### rtl/c2s_pkg.sv
// Shared types and constants of the cube map to sphere map address block.
// No dependencies.
package c2s_pkg;

    localparam int QB      = 17;     // quotient and root bits (Q16 magnitude up to 1.0)
    localparam int RW      = 18;     // magnitude width of reflection components
    localparam int RADW    = 33;     // radicand width, up to 2^32
    localparam int ONE_Q16 = 65536;

    typedef enum logic [2:0] {
        FACE_NEG_X = 3'd0,
        FACE_POS_X = 3'd1,
        FACE_NEG_Y = 3'd2,
        FACE_POS_Y = 3'd3,
        FACE_POS_Z = 3'd4,
        FACE_NEG_Z = 3'd5
    } face_t;

    typedef struct packed {
        logic valid;
        logic oor;
        logic sx_neg;
        logic sy_neg;
    } pre_t;

    typedef struct packed {
        logic          valid;
        logic          hit;
        logic          sx_neg;
        logic          sy_neg;
        logic [QB-1:0] s_mag;
        logic [QB-1:0] t_mag;
    } disc_t;

    typedef struct packed {
        logic valid;
        logic hit;
        logic rx_neg;
        logic ry_neg;
        logic rz_neg;
        logic rz_pos;
    } refl_t;

    typedef struct packed {
        logic  valid;
        logic  hit;
        face_t face;
        logic  qx_neg;
        logic  qy_neg;
        logic  zero;
    } face_sel_t;

endpackage

### rtl/cubemap_to_spheremap_address.sv
// Top level of the cube map to sphere map address generator.
// Uses c2s_pkg, c2s_div, c2s_sqrt, c2s_delay and the assertion macro header.
//
// Usage:
//   Configuration: cfg_we with cfg_wdata writes face_size (edge length N);
//   write only while no transaction is in flight. Reset sets N to 256.
//   Input: a transaction is taken at each rising edge with start high and busy
//   low. busy never rises: the pipeline takes one pixel every cycle.
//   Output: done is high for one cycle with inside_res, src_x and src_y.
//   Results leave in input order, after passing through three 17-stage
//   pipelined units, for s/t division, square root and face division, plus
//   eight arithmetic stages. Throughput is one per cycle.
//   The receiver cannot stall; results must be taken as they appear.
//   Reset clears all valid bits, so nothing in flight emerges afterwards.
//   Pixels off the map or outside the disc return inside_res 0 with zero
//   coordinates.
`include "cubemap_to_spheremap_address_assert.svh"
module cubemap_to_spheremap_address #(
    parameter int MAX_FACE = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [12:0] cfg_wdata,
    input  logic        start,
    input  logic [11:0] pix_x,
    input  logic [11:0] pix_y,
    output logic        busy,
    output logic        done,
    output logic        inside_res,
    output logic [14:0] src_x,
    output logic [11:0] src_y
);
    import c2s_pkg::*;

    localparam int NW  = $clog2(MAX_FACE + 1);
    localparam int NMW = $clog2(MAX_FACE);
    localparam int AW  = NMW + 2;
    localparam int PW  = RW + NMW;
    localparam int LAT = 3 * QB + 8;

    // configuration
    logic [12:0]    face_size_reg;
    logic [NW-1:0]  n_eff;
    logic [NMW-1:0] nm1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            face_size_reg <= 13'd256;
        end
        else if (cfg_we)
        begin
            face_size_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        if (int'(face_size_reg) < 2)
        begin
            n_eff = NW'(2);
        end
        else if (int'(face_size_reg) > MAX_FACE)
        begin
            n_eff = NW'(MAX_FACE);
        end
        else
        begin
            n_eff = NW'(face_size_reg);
        end
    end

    assign nm1  = NMW'(n_eff - NW'(1));
    assign busy = 1'b0;

    // stage A: centre the pixel
    logic                  accept;
    logic signed [AW-1:0]  ax_c;
    logic signed [AW-1:0]  ay_c;
    logic [NMW-1:0]        amx_reg;
    logic [NMW-1:0]        amy_reg;
    pre_t                  a_next;
    pre_t                  a_reg;

    assign accept = start && !busy;
    assign ax_c   = signed'(AW'({pix_x, 1'b0})) - signed'(AW'(nm1));
    assign ay_c   = signed'(AW'({pix_y, 1'b0})) - signed'(AW'(nm1));

    always_comb
    begin
        a_next.valid  = accept;
        a_next.oor    = (int'(pix_x) >= int'(n_eff)) || (int'(pix_y) >= int'(n_eff));
        a_next.sx_neg = ax_c[AW-1];
        a_next.sy_neg = ay_c[AW-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg <= '0;
        end
        else
        begin
            a_reg <= a_next;
        end
    end

    always_ff @(posedge clk)
    begin
        amx_reg <= ax_c[AW-1] ? NMW'(-ax_c) : NMW'(ax_c);
        amy_reg <= ay_c[AW-1] ? NMW'(-ay_c) : NMW'(ay_c);
    end

    // s and t magnitudes in Q16
    logic [QB-1:0] s_mag;
    logic [QB-1:0] t_mag;
    pre_t          a_dly;

    c2s_div #(.DW(NMW)) u_div_s (.clk(clk), .num(amx_reg), .den(nm1), .quot(s_mag));
    c2s_div #(.DW(NMW)) u_div_t (.clk(clk), .num(amy_reg), .den(nm1), .quot(t_mag));
    c2s_delay #(.W($bits(pre_t)), .D(QB)) u_dly_a (
        .clk(clk), .rst_n(rst_n), .din(a_reg), .dout(a_dly)
    );

    // stage B: squares
    logic [2*QB-1:0] sq_s_reg;
    logic [2*QB-1:0] sq_t_reg;
    disc_t           b_next;
    disc_t           b_reg;

    always_comb
    begin
        b_next.valid  = a_dly.valid;
        b_next.hit    = !a_dly.oor;    // in range for now
        b_next.sx_neg = a_dly.sx_neg;
        b_next.sy_neg = a_dly.sy_neg;
        b_next.s_mag  = s_mag;
        b_next.t_mag  = t_mag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_reg <= '0;
        end
        else
        begin
            b_reg <= b_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_s_reg <= s_mag * s_mag;
        sq_t_reg <= t_mag * t_mag;
    end

    // stage C: disc test and radicand
    logic [2*QB:0]   r2;
    logic            in_disc;
    logic [RADW-1:0] rad_reg;
    disc_t           c_next;
    disc_t           c_reg;

    assign r2      = {1'b0, sq_s_reg} + {1'b0, sq_t_reg};
    assign in_disc = b_reg.hit && (r2 <= ((2*QB+1)'(1) << 32));

    always_comb
    begin
        c_next     = b_reg;
        c_next.hit = in_disc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_reg <= '0;
        end
        else
        begin
            c_reg <= c_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg <= in_disc ? RADW'(((2*QB+1)'(1) << 32) - r2) : '0;
    end

    // z = sqrt(1 - s^2 - t^2)
    logic [QB-1:0] z_root;
    disc_t         c_dly;

    c2s_sqrt u_sqrt (.clk(clk), .rad(rad_reg), .root(z_root));
    c2s_delay #(.W($bits(disc_t)), .D(QB)) u_dly_c (
        .clk(clk), .rst_n(rst_n), .din(c_reg), .dout(c_dly)
    );

    // stage D: products with z
    logic [2*QB-1:0] psz_reg;
    logic [2*QB-1:0] ptz_reg;
    logic [2*QB-1:0] pzz_reg;
    disc_t           d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_reg <= '0;
        end
        else
        begin
            d_reg <= c_dly;
        end
    end

    always_ff @(posedge clk)
    begin
        psz_reg <= c_dly.s_mag * z_root;
        ptz_reg <= c_dly.t_mag * z_root;
        pzz_reg <= z_root * z_root;
    end

    // stage E: reflection vector as sign and magnitude
    logic [RW-1:0] rx_m;
    logic [RW-1:0] ry_m;
    logic [RW-1:0] rz_p;
    logic          rz_n;
    logic [RW-1:0] rxm_reg;
    logic [RW-1:0] rym_reg;
    logic [RW-1:0] rzm_reg;
    refl_t         e_next;
    refl_t         e_reg;

    assign rx_m = RW'(psz_reg >> 15);
    assign ry_m = RW'(ptz_reg >> 15);
    assign rz_p = RW'(pzz_reg >> 15);
    assign rz_n = rz_p < RW'(ONE_Q16);

    always_comb
    begin
        e_next.valid  = d_reg.valid;
        e_next.hit    = d_reg.hit;
        e_next.rx_neg = d_reg.sx_neg && (rx_m != '0);
        e_next.ry_neg = d_reg.sy_neg && (ry_m != '0);
        e_next.rz_neg = rz_n;
        e_next.rz_pos = !rz_n && (rz_p != RW'(ONE_Q16));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_reg <= '0;
        end
        else
        begin
            e_reg <= e_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rxm_reg <= rx_m;
        rym_reg <= ry_m;
        rzm_reg <= rz_n ? RW'(ONE_Q16) - rz_p : rz_p - RW'(ONE_Q16);
    end

    // stage F: major axis, face and quotient operands
    face_sel_t     f_next;
    face_sel_t     f_reg;
    logic [RW-1:0] nx_next;
    logic [RW-1:0] ny_next;
    logic [RW-1:0] den_next;
    logic [RW-1:0] nx_reg;
    logic [RW-1:0] ny_reg;
    logic [RW-1:0] den_reg;

    always_comb
    begin
        f_next.valid = e_reg.valid;
        f_next.hit   = e_reg.hit;
        if (rxm_reg >= rym_reg && rxm_reg >= rzm_reg)
        begin
            f_next.face   = e_reg.rx_neg ? FACE_NEG_X : FACE_POS_X;
            nx_next       = rzm_reg;
            ny_next       = rym_reg;
            den_next      = rxm_reg;
            f_next.qx_neg = e_reg.rz_neg ^ e_reg.rx_neg;
            f_next.qy_neg = e_reg.ry_neg;
        end
        else if (rym_reg >= rzm_reg)
        begin
            f_next.face   = e_reg.ry_neg ? FACE_NEG_Y : FACE_POS_Y;
            nx_next       = rxm_reg;
            ny_next       = rzm_reg;
            den_next      = rym_reg;
            f_next.qx_neg = !e_reg.rx_neg;
            f_next.qy_neg = e_reg.rz_neg ^ !e_reg.ry_neg;
        end
        else
        begin
            f_next.face   = e_reg.rz_pos ? FACE_POS_Z : FACE_NEG_Z;
            nx_next       = rxm_reg;
            ny_next       = rym_reg;
            den_next      = rzm_reg;
            f_next.qx_neg = e_reg.rx_neg ^ !e_reg.rz_neg;
            f_next.qy_neg = e_reg.ry_neg;
        end
        // all components zero: face centre
        f_next.zero = (den_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_reg <= '0;
        end
        else
        begin
            f_reg <= f_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nx_reg  <= nx_next;
        ny_reg  <= ny_next;
        den_reg <= den_next;
    end

    // face quotients
    logic [QB-1:0] qx_mag;
    logic [QB-1:0] qy_mag;
    face_sel_t     f_dly;

    c2s_div #(.DW(RW)) u_div_qx (.clk(clk), .num(nx_reg), .den(den_reg), .quot(qx_mag));
    c2s_div #(.DW(RW)) u_div_qy (.clk(clk), .num(ny_reg), .den(den_reg), .quot(qy_mag));
    c2s_delay #(.W($bits(face_sel_t)), .D(QB)) u_dly_f (
        .clk(clk), .rst_n(rst_n), .din(f_reg), .dout(f_dly)
    );

    // stage G: shift to [0, 2] and scale by N-1
    logic signed [RW:0] qx_s;
    logic signed [RW:0] qy_s;
    logic [RW-1:0]      ux;
    logic [RW-1:0]      uy;
    logic [PW-1:0]      prx_reg;
    logic [PW-1:0]      pry_reg;
    face_sel_t          g_reg;

    always_comb
    begin
        if (f_dly.zero)
        begin
            qx_s = '0;
            qy_s = '0;
        end
        else
        begin
            qx_s = f_dly.qx_neg ? -signed'((RW+1)'(qx_mag)) : signed'((RW+1)'(qx_mag));
            qy_s = f_dly.qy_neg ? -signed'((RW+1)'(qy_mag)) : signed'((RW+1)'(qy_mag));
        end
    end

    assign ux = RW'(qx_s + signed'((RW+1)'(ONE_Q16)));
    assign uy = RW'(qy_s + signed'((RW+1)'(ONE_Q16)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_reg <= '0;
        end
        else
        begin
            g_reg <= f_dly;
        end
    end

    always_ff @(posedge clk)
    begin
        prx_reg <= PW'(ux) * PW'(nm1);
        pry_reg <= PW'(uy) * PW'(nm1);
    end

    // stage H: floor, clamp, face offset, output register
    logic [NMW:0]  cx_raw;
    logic [NMW:0]  cy_raw;
    logic [NMW:0]  cx;
    logic [NMW:0]  cy;
    logic [NW+2:0] offset;
    logic          done_reg;
    logic          inside_res_reg;
    logic [14:0]   src_x_reg;
    logic [11:0]   src_y_reg;
    logic [14:0]   src_x_next;
    logic [11:0]   src_y_next;

    assign cx_raw = (NMW+1)'(prx_reg >> 17);
    assign cy_raw = (NMW+1)'(pry_reg >> 17);
    assign cx     = (cx_raw > (NMW+1)'(nm1)) ? (NMW+1)'(nm1) : cx_raw;
    assign cy     = (cy_raw > (NMW+1)'(nm1)) ? (NMW+1)'(nm1) : cy_raw;
    assign offset = (NW+3)'(g_reg.face) * (NW+3)'(n_eff);

    assign src_x_next = g_reg.hit ? 15'(32'(offset) + 32'(cx)) : '0;
    assign src_y_next = g_reg.hit ? 12'(cy) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= g_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        inside_res_reg <= g_reg.hit;
        src_x_reg      <= src_x_next;
        src_y_reg      <= src_y_next;
    end

    assign done       = done_reg;
    assign inside_res = inside_res_reg;
    assign src_x      = src_x_reg;
    assign src_y      = src_y_reg;

    `C2S_ASSERT_DELAY(a_lat_on, clk, rst_n, accept, LAT, done, "result missing after latency")
    `C2S_ASSERT_DELAY(a_lat_off, clk, rst_n, !accept, LAT, !done, "result without transaction")
    `C2S_ASSERT_IMPL(a_reject_zero, clk, rst_n, done && !inside_res, src_x == '0 && src_y == '0, "rejected pixel has nonzero source")

endmodule

### rtl/c2s_delay.sv
// Fixed-length delay line carrying side data alongside the arithmetic units.
// No dependencies.
module c2s_delay #(
    parameter int W = 1,
    parameter int D = 1
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] line_reg [D];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < D; i++)
            begin
                line_reg[i] <= '0;
            end
        end
        else
        begin
            line_reg[0] <= din;
            for (int i = 1; i < D; i++)
            begin
                line_reg[i] <= line_reg[i-1];
            end
        end
    end

    assign dout = line_reg[D-1];

endmodule

### rtl/c2s_div.sv
// Pipelined restoring divider, one quotient bit per stage: (num << 16) / den.
// Requires num <= den so the quotient fits QB bits. Uses c2s_pkg.
module c2s_div #(
    parameter int DW = 12
) (
    input  logic                  clk,
    input  logic [DW-1:0]         num,
    input  logic [DW-1:0]         den,
    output logic [c2s_pkg::QB-1:0] quot
);
    import c2s_pkg::*;

    logic [DW-1:0] rem_reg  [QB];
    logic [DW-1:0] den_reg  [QB];
    logic [QB-1:0] quot_reg [QB];

    for (genvar k = 0; k < QB; k++)
    begin : g_step
        logic [DW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [QB-1:0] quot_in;
        logic          bit_in;
        logic [DW:0]   cand;
        logic          take;
        logic [DW-1:0] rem_next;
        logic [QB-1:0] quot_next;

        if (k == 0)
        begin : g_first
            // top numerator bits are num itself; only num[0] lands in the quotient range
            assign rem_in  = num >> 1;
            assign den_in  = den;
            assign quot_in = '0;
            assign bit_in  = num[0];
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign den_in  = den_reg[k-1];
            assign quot_in = quot_reg[k-1];
            assign bit_in  = 1'b0;
        end

        assign cand      = {rem_in, bit_in};
        assign take      = cand >= {1'b0, den_in};
        assign rem_next  = take ? DW'(cand - {1'b0, den_in}) : DW'(cand);
        assign quot_next = quot_in | (take ? (QB'(1) << (QB - 1 - k)) : '0);

        always_ff @(posedge clk)
        begin
            rem_reg[k]  <= rem_next;
            den_reg[k]  <= den_in;
            quot_reg[k] <= quot_next;
        end
    end

    assign quot = quot_reg[QB-1];

endmodule

### rtl/c2s_sqrt.sv
// Pipelined bitwise integer square root of a 33-bit radicand, one step per stage.
// Uses c2s_pkg.
module c2s_sqrt (
    input  logic                     clk,
    input  logic [c2s_pkg::RADW-1:0] rad,
    output logic [c2s_pkg::QB-1:0]   root
);
    import c2s_pkg::*;

    logic [RADW:0] val_reg [QB];
    logic [RADW:0] res_reg [QB];

    for (genvar k = 0; k < QB; k++)
    begin : g_step
        localparam logic [RADW:0] BITV = (RADW+1)'(1) << (2 * (QB - 1 - k));
        logic [RADW:0] val_in;
        logic [RADW:0] res_in;
        logic [RADW:0] trial;
        logic          take;
        logic [RADW:0] val_next;
        logic [RADW:0] res_next;

        if (k == 0)
        begin : g_first
            assign val_in = {1'b0, rad};
            assign res_in = '0;
        end
        else
        begin : g_rest
            assign val_in = val_reg[k-1];
            assign res_in = res_reg[k-1];
        end

        assign trial    = res_in + BITV;
        assign take     = val_in >= trial;
        assign val_next = take ? val_in - trial : val_in;
        assign res_next = take ? (res_in >> 1) + BITV : res_in >> 1;

        always_ff @(posedge clk)
        begin
            val_reg[k] <= val_next;
            res_reg[k] <= res_next;
        end
    end

    assign root = res_reg[QB-1][QB-1:0];

endmodule
